// ===== design/bpcr_pkg.sv =====
`timescale 1ns / 1ps

package bpcr_pkg;

  // Register indexes on the configuration port (byte address is 4 * index)
  localparam logic [2:0] CfgOpen     = 3'd0;
  localparam logic [2:0] CfgWidth    = 3'd1;
  localparam logic [2:0] CfgHeight   = 3'd2;
  localparam logic [2:0] CfgBottomUp = 3'd3;
  localparam logic [2:0] CfgOffset   = 3'd4;
  localparam logic [2:0] CfgFormat   = 3'd5;

  // Pixel formats
  localparam logic [1:0] FmtRgb555 = 2'd0;
  localparam logic [1:0] FmtBgr24  = 2'd1;
  localparam logic [1:0] FmtBgrx32 = 2'd2;

  // Result status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StNotOpen   = 2'd1;
  localparam logic [1:0] StSeekRange = 2'd2;
  localparam logic [1:0] StAtEnd     = 2'd3;

  // Actions
  localparam logic ActSeek = 1'b0;
  localparam logic ActRead = 1'b1;

  // Column wrap divider: dividend is column + 1, divisor is the usable width
  localparam int unsigned DivW   = 13;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  typedef struct packed {
    logic start;
    logic ack;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// ===== design/bpcr_in_if.sv =====
`timescale 1ns / 1ps

interface bpcr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [11:0] seek_x;
  logic [11:0] seek_y;
  logic [31:0] pixel_word;
  logic        advance_after;

  modport source (
    output valid, action, seek_x, seek_y, pixel_word, advance_after,
    input  ready
  );

  modport sink (
    input  valid, action, seek_x, seek_y, pixel_word, advance_after,
    output ready
  );
endinterface

// ===== design/bpcr_out_if.sv =====
`timescale 1ns / 1ps

interface bpcr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] pixel_address;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [1:0]  status;

  modport source (
    output valid, red, green, blue, pixel_address, cursor_x, cursor_y, status,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, pixel_address, cursor_x, cursor_y, status,
    output ready
  );
endinterface

// ===== design/bpcr_div.sv =====
`timescale 1ns / 1ps

module bpcr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpcr_pkg::div_req_t           req_i,
  output bpcr_pkg::div_rsp_t           rsp_o,
  input  logic [bpcr_pkg::DivW-1:0]    dividend_i,
  input  logic [bpcr_pkg::DivW-1:0]    divisor_i,
  output logic [bpcr_pkg::DivW-1:0]    quot_o,
  output logic [bpcr_pkg::DivW-1:0]    rem_o
);

  logic                            busy_q, done_q;
  logic [bpcr_pkg::DivCntW-1:0]    cnt_q;
  logic [bpcr_pkg::DivW-1:0]       quo_q, rem_q;
  logic [bpcr_pkg::DivW-1:0]       shifted;
  logic [bpcr_pkg::DivW:0]         diff;

  // One restoring step: shift in the next dividend bit and try the subtract
  assign shifted = {rem_q[bpcr_pkg::DivW-2:0], quo_q[bpcr_pkg::DivW-1]};
  assign diff    = {1'b0, shifted} - {1'b0, divisor_i};

  // Control: start loads, count down one bit a cycle, hold done until ack
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= bpcr_pkg::DivCntW'(bpcr_pkg::DivW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == bpcr_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (req_i.ack) begin
      done_q <= 1'b0;
    end
  end

  // Datapath: quotient bits shift in where the dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[bpcr_pkg::DivW]) begin
        rem_q <= diff[bpcr_pkg::DivW-1:0];
        quo_q <= {quo_q[bpcr_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[bpcr_pkg::DivW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quot_o     = quo_q;
  assign rem_o      = rem_q;

endmodule

// ===== design/bmp_pixel_cursor_reader_top.sv =====
`timescale 1ns / 1ps

// Pixel cursor and byte-address generator for an uncompressed bitmap, with
// pixel unpack. Each transaction on in_i (seek or read) yields exactly one
// transaction on out_o carrying decoded color, the cursor, its byte address
// and a status. The block takes one transaction per cycle while no result is
// stalled: an item sits in a working register while the cursor update, the
// row-times-stride multiply and the address add run, and its result lands in
// an output register that decouples the downstream ready. The one exception
// is a read that advances a cursor whose column lies at or past the usable
// width (possible only after the width has been reprogrammed): the row wrap
// goes through a bit-serial divider, and the item holds the working register
// until the divide is done. The user must write registers over the APB port
// only while no transaction is in flight; the block does not enforce it.
// Cursor and address reset to zero and are never moved by register writes.
module bmp_pixel_cursor_reader_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channels
  bpcr_in_if.sink     in_i,
  bpcr_out_if.source  out_o
);

  localparam int unsigned WLim = (MAX_WIDTH  < 4096) ? MAX_WIDTH  : 4096;
  localparam int unsigned HLim = (MAX_HEIGHT < 4096) ? MAX_HEIGHT : 4096;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        open_q, bottom_up_q;
  logic [12:0] width_q, height_q;
  logic [31:0] offset_q;
  logic [1:0]  format_q;
  logic        cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      width_q     <= 13'd1;
      height_q    <= 13'd1;
      bottom_up_q <= 1'b1;
      offset_q    <= 32'd54;
      format_q    <= bpcr_pkg::FmtBgr24;
    end else if (cfg_we) begin
      case (paddr[4:2])
        bpcr_pkg::CfgOpen:     open_q      <= pwdata[0];
        bpcr_pkg::CfgWidth:    width_q     <= pwdata[12:0];
        bpcr_pkg::CfgHeight:   height_q    <= pwdata[12:0];
        bpcr_pkg::CfgBottomUp: bottom_up_q <= pwdata[0];
        bpcr_pkg::CfgOffset:   offset_q    <= pwdata;
        bpcr_pkg::CfgFormat:   format_q    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[4:2])
      bpcr_pkg::CfgOpen:     prdata = {31'b0, open_q};
      bpcr_pkg::CfgWidth:    prdata = {19'b0, width_q};
      bpcr_pkg::CfgHeight:   prdata = {19'b0, height_q};
      bpcr_pkg::CfgBottomUp: prdata = {31'b0, bottom_up_q};
      bpcr_pkg::CfgOffset:   prdata = offset_q;
      bpcr_pkg::CfgFormat:   prdata = {30'b0, format_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Working register
  // ---------------------------------------------------------------------------
  logic        stg_vld_q;
  logic        act_q, adv_q;
  logic [11:0] sx_q, sy_q;
  logic [31:0] word_q;
  logic        stg_fire, in_xfer;

  assign in_i.ready = !stg_vld_q || stg_fire;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_xfer) begin
      stg_vld_q <= 1'b1;
    end else if (stg_fire) begin
      stg_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q  <= in_i.action;
      sx_q   <= in_i.seek_x;
      sy_q   <= in_i.seek_y;
      word_q <= in_i.pixel_word;
      adv_q  <= in_i.advance_after;
    end
  end

  // ---------------------------------------------------------------------------
  // Cursor state
  // ---------------------------------------------------------------------------
  logic [11:0] cur_col_q, cur_row_q;
  logic [31:0] cur_addr_q;

  // ---------------------------------------------------------------------------
  // Geometry derived from the registers
  // ---------------------------------------------------------------------------
  logic [12:0] w_use, h_use;
  logic [2:0]  bpp;
  logic [14:0] row_bytes;
  logic [15:0] stride;

  assign w_use = (width_q  > 13'(WLim)) ? 13'(WLim) : width_q;
  assign h_use = (height_q > 13'(HLim)) ? 13'(HLim) : height_q;

  always_comb begin
    case (format_q)
      bpcr_pkg::FmtRgb555: begin
        bpp       = 3'd2;
        row_bytes = {1'b0, width_q, 1'b0};
      end
      bpcr_pkg::FmtBgrx32: begin
        bpp       = 3'd4;
        row_bytes = {width_q, 2'b00};
      end
      default: begin
        bpp       = 3'd3;
        row_bytes = {1'b0, width_q, 1'b0} + {2'b0, width_q};
      end
    endcase
  end

  assign stride = ({1'b0, row_bytes} + 16'd3) & ~16'd3;

  // ---------------------------------------------------------------------------
  // Advance: next column and row, with the divider for a far-out column
  // ---------------------------------------------------------------------------
  logic [12:0]                    col_inc;
  logic [bpcr_pkg::DivW-1:0]      div_quot, div_rem;
  bpcr_pkg::div_req_t             div_req;
  bpcr_pkg::div_rsp_t             div_rsp;
  logic                           row_in, need_div, stall;
  logic [11:0]                    nx;
  logic [13:0]                    ny;
  logic                           step_ok;

  assign col_inc = {1'b0, cur_col_q} + 13'd1;
  assign row_in  = (w_use != 13'd0) && ({1'b0, cur_row_q} < h_use);

  assign need_div = stg_vld_q && open_q && (act_q == bpcr_pkg::ActRead) && adv_q &&
                    row_in && (col_inc > w_use);
  assign stall    = need_div && !div_rsp.done;

  assign div_req.start = need_div && !div_rsp.busy && !div_rsp.done;
  assign div_req.ack   = stg_fire;

  bpcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rsp_o      (div_rsp),
    .dividend_i (col_inc),
    .divisor_i  (w_use),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    if (col_inc < w_use) begin
      nx = col_inc[11:0];
      ny = {2'b0, cur_row_q};
    end else if (col_inc == w_use) begin
      nx = '0;
      ny = {2'b0, cur_row_q} + 14'd1;
    end else begin
      nx = div_rem[11:0];
      ny = {2'b0, cur_row_q} + {1'b0, div_quot};
    end
  end

  assign step_ok = row_in && (ny < {1'b0, h_use});

  // ---------------------------------------------------------------------------
  // Decide the step: status, whether the cursor moves and where to
  // ---------------------------------------------------------------------------
  logic        seek_ok, move;
  logic [1:0]  status_d;
  logic [11:0] pl_x, pl_y;

  assign seek_ok = ({1'b0, sx_q} < w_use) && ({1'b0, sy_q} < h_use);

  always_comb begin
    status_d = bpcr_pkg::StOk;
    move     = 1'b0;
    pl_x     = sx_q;
    pl_y     = sy_q;
    if (!open_q) begin
      status_d = bpcr_pkg::StNotOpen;
    end else if (act_q == bpcr_pkg::ActSeek) begin
      if (seek_ok) begin
        move = 1'b1;
      end else begin
        status_d = bpcr_pkg::StSeekRange;
      end
    end else if (adv_q) begin
      pl_x = nx;
      pl_y = ny[11:0];
      if (step_ok) begin
        move = 1'b1;
      end else begin
        status_d = bpcr_pkg::StAtEnd;
      end
    end
  end

  // Byte address of the new cursor position, rows flipped for bottom-up
  logic [31:0] frow, row_off, addr_new;
  logic [14:0] col_off;

  assign frow     = bottom_up_q ? ({19'b0, height_q} - {20'b0, pl_y} - 32'd1)
                                : {20'b0, pl_y};
  assign row_off  = frow * {16'b0, stride};
  assign col_off  = {3'b0, pl_x} * {12'b0, bpp};
  assign addr_new = offset_q + row_off + {17'b0, col_off};

  // ---------------------------------------------------------------------------
  // Pixel unpack
  // ---------------------------------------------------------------------------
  logic [7:0] red_d, green_d, blue_d;
  logic [4:0] r5, g5, b5;

  assign r5 = word_q[14:10];
  assign g5 = word_q[9:5];
  assign b5 = word_q[4:0];

  always_comb begin
    if (!open_q || (act_q == bpcr_pkg::ActSeek)) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else if (format_q == bpcr_pkg::FmtRgb555) begin
      red_d   = {r5, r5[4:2]};
      green_d = {g5, g5[4:2]};
      blue_d  = {b5, b5[4:2]};
    end else begin
      red_d   = word_q[23:16];
      green_d = word_q[15:8];
      blue_d  = word_q[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Retire: update the cursor and load the output register
  // ---------------------------------------------------------------------------
  logic        out_vld_q;
  logic [11:0] col_next, row_next;
  logic [31:0] addr_next;

  assign stg_fire = stg_vld_q && (!out_vld_q || out_o.ready) && !stall;

  assign col_next  = move ? pl_x     : cur_col_q;
  assign row_next  = move ? pl_y     : cur_row_q;
  assign addr_next = move ? addr_new : cur_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      cur_addr_q <= '0;
    end else if (stg_fire) begin
      cur_col_q  <= col_next;
      cur_row_q  <= row_next;
      cur_addr_q <= addr_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stg_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  logic [7:0]  red_q, green_q, blue_q;
  logic [31:0] oaddr_q;
  logic [11:0] ox_q, oy_q;
  logic [1:0]  status_q;

  always_ff @(posedge clk_i) begin
    if (stg_fire) begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      oaddr_q  <= addr_next;
      ox_q     <= col_next;
      oy_q     <= row_next;
      status_q <= status_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.red           = red_q;
  assign out_o.green         = green_q;
  assign out_o.blue          = blue_q;
  assign out_o.pixel_address = oaddr_q;
  assign out_o.cursor_x      = ox_q;
  assign out_o.cursor_y      = oy_q;
  assign out_o.status        = status_q;

endmodule

// ===== design/bpcr_checker.sv =====
`timescale 1ns / 1ps

module bpcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  red_i,
  input logic [7:0]  green_i,
  input logic [7:0]  blue_i,
  input logic [31:0] pixel_address_i,
  input logic [11:0] cursor_x_i,
  input logic [11:0] cursor_y_i,
  input logic [1:0]  status_i
);

  // Hold a stalled result transaction unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({red_i, green_i, blue_i, pixel_address_i, cursor_x_i, cursor_y_i, status_i}))
    else $error("result changed while stalled");

  // Drop color on a failed seek or a closed image
  a_fail_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == bpcr_pkg::StNotOpen) ||
                    (status_i == bpcr_pkg::StSeekRange))
      |-> (red_i == 8'd0) && (green_i == 8'd0) && (blue_i == 8'd0))
    else $error("color on a failed transaction");

  // Come out of reset ready for input
  a_ready_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_ready_i && !out_valid_i)
    else $error("not ready after reset");

endmodule

bind bmp_pixel_cursor_reader_top bpcr_checker u_bpcr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .red_i           (out_o.red),
  .green_i         (out_o.green),
  .blue_i          (out_o.blue),
  .pixel_address_i (out_o.pixel_address),
  .cursor_x_i      (out_o.cursor_x),
  .cursor_y_i      (out_o.cursor_y),
  .status_i        (out_o.status)
);
